// ----- design/wpd_pkg.sv -----
// shared types and constants for the waveform peak decimator
package wpd_pkg;

   // sample format
   localparam int SAMPLE_BITS = 16;
   localparam int DIFF_W      = SAMPLE_BITS + 1;

   // configuration register widths
   localparam int CHAN_W      = 4;
   localparam int HEIGHT_W    = 13;
   localparam int PAD_W       = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   // channel position and row arithmetic
   localparam int POS_W   = 3;
   localparam int PROD_W  = HEIGHT_W + DIFF_W;
   localparam int ROUND_W = PROD_W - SAMPLE_BITS;
   localparam int PSUM_W  = ROUND_W + 1;
   localparam int ROW_W   = 12;

   // limits of the configuration values
   localparam logic [CHAN_W-1:0]   CHAN_MIN   = CHAN_W'(1);
   localparam logic [CHAN_W-1:0]   CHAN_MAX   = CHAN_W'(8);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = HEIGHT_W'(2);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = HEIGHT_W'(4096);

   // reset values of the configuration registers
   localparam logic [CHAN_W-1:0]   CHAN_RESET   = CHAN_W'(1);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(165);
   localparam logic [PAD_W-1:0]    PAD_RESET    = PAD_W'(2);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_EDGE_PADDING  = CSR_INDEX_W'(2);

   // input word
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          block_end;
   } req_word_type;

   // result word
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] first_value;
      logic signed [SAMPLE_BITS-1:0] second_value;
      logic [ROW_W-1:0]              first_row;
      logic [ROW_W-1:0]              second_row;
      logic                          flat_block;
   } rsp_word_type;

   // closed block, extremes in time order
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] first_value;
      logic signed [SAMPLE_BITS-1:0] second_value;
      logic                          flat_block;
   } closed_word_type;

   // closed block with scaled extremes
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] first_value;
      logic signed [SAMPLE_BITS-1:0] second_value;
      logic                          flat_block;
      logic [PROD_W-1:0]             first_prod;
      logic [PROD_W-1:0]             second_prod;
   } scaled_word_type;

   // cleaned configuration seen by the stages
   typedef struct packed {
      logic [CHAN_W-1:0]   chans;
      logic [HEIGHT_W-1:0] height;
      logic                height_small;
      logic [HEIGHT_W-1:0] row_limit;
      logic [PAD_W-1:0]    padding;
   } cfg_type;

endpackage

// ----- design/wpd_tracker.sv -----
// channel 0 min/max tracking per block, closed block register
module wpd_tracker (
   input  logic                     clock,
   input  logic                     reset,
   input  wpd_pkg::cfg_type         cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  wpd_pkg::req_word_type    in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output wpd_pkg::closed_word_type out_data
);

   logic signed [wpd_pkg::SAMPLE_BITS-1:0] min_ff, min_in, max_ff, max_in;
   logic signed [wpd_pkg::SAMPLE_BITS-1:0] upd_min, upd_max;
   logic                                   later_ff, later_in, upd_later;
   logic                                   started_ff, started_in;
   logic [wpd_pkg::POS_W-1:0]              pos_ff, pos_in;
   logic                                   accept;
   logic                                   valid_ff, valid_in;
   wpd_pkg::closed_word_type               data_ff, data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // compare and update on channel 0 of each frame
   always_comb begin
      upd_min   = min_ff;
      upd_max   = max_ff;
      upd_later = later_ff;
      if (pos_ff == '0) begin
         if (!started_ff) begin
            upd_min   = in_data.sample;
            upd_max   = in_data.sample;
            upd_later = 1'b0;
         end else begin
            if (in_data.sample > max_ff) begin
               upd_max   = in_data.sample;
               upd_later = 1'b1;
            end
            if (in_data.sample < min_ff) begin
               upd_min   = in_data.sample;
               upd_later = 1'b0;
            end
         end
      end
   end

   // next state, cleared at block end
   always_comb begin
      min_in     = min_ff;
      max_in     = max_ff;
      later_in   = later_ff;
      started_in = started_ff;
      pos_in     = pos_ff;
      if (accept) begin
         min_in     = upd_min;
         max_in     = upd_max;
         later_in   = upd_later;
         started_in = started_ff || (pos_ff == '0);
         if (({1'b0, pos_ff} + wpd_pkg::CHAN_W'(1)) >= cfg.chans) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + wpd_pkg::POS_W'(1);
         end
         if (in_data.block_end) begin
            min_in     = '0;
            max_in     = '0;
            later_in   = 1'b0;
            started_in = 1'b0;
            pos_in     = '0;
         end
      end
   end

   // extremes in time order, maximum first on a tie
   always_comb begin
      if (upd_later) begin
         data_in.first_value  = upd_min;
         data_in.second_value = upd_max;
      end else begin
         data_in.first_value  = upd_max;
         data_in.second_value = upd_min;
      end
      data_in.flat_block = (upd_min == upd_max);
   end

   // closed block slot
   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = accept && in_data.block_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= '0;
         max_ff     <= '0;
         later_ff   <= 1'b0;
         started_ff <= 1'b0;
         pos_ff     <= '0;
         valid_ff   <= 1'b0;
      end else begin
         min_ff     <= min_in;
         max_ff     <= max_in;
         later_ff   <= later_in;
         started_ff <= started_in;
         pos_ff     <= pos_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_data.block_end) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- design/wpd_scale.sv -----
// scales both extremes by the image height
module wpd_scale (
   input  logic                     clock,
   input  logic                     reset,
   input  wpd_pkg::cfg_type         cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  wpd_pkg::closed_word_type in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output wpd_pkg::scaled_word_type out_data
);

   // distance from the top of the range: 2^(B-1) - s, 1 .. 2^B
   function automatic logic [wpd_pkg::DIFF_W-1:0] top_distance(
      input logic signed [wpd_pkg::SAMPLE_BITS-1:0] s
   );
      logic signed [wpd_pkg::DIFF_W:0] diff;
      diff = $signed({2'b00, 1'b1, {(wpd_pkg::SAMPLE_BITS-1){1'b0}}})
             - (wpd_pkg::DIFF_W+1)'(s);
      return diff[wpd_pkg::DIFF_W-1:0];
   endfunction

   logic                     accept;
   logic                     valid_ff, valid_in;
   wpd_pkg::scaled_word_type data_ff, data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // one multiplier per extreme
   always_comb begin
      data_in.first_value  = in_data.first_value;
      data_in.second_value = in_data.second_value;
      data_in.flat_block   = in_data.flat_block;
      data_in.first_prod   = wpd_pkg::PROD_W'(cfg.height)
                             * wpd_pkg::PROD_W'(top_distance(in_data.first_value));
      data_in.second_prod  = wpd_pkg::PROD_W'(cfg.height)
                             * wpd_pkg::PROD_W'(top_distance(in_data.second_value));
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- design/wpd_clamp.sv -----
// rounding, padding and saturation to image rows, result register
module wpd_clamp (
   input  logic                     clock,
   input  logic                     reset,
   input  wpd_pkg::cfg_type         cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  wpd_pkg::scaled_word_type in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output wpd_pkg::rsp_word_type    out_data
);

   // round half up, add padding, saturate to the row limit; row 0 when the height is below the minimum
   function automatic logic [wpd_pkg::ROW_W-1:0] to_row(
      input logic [wpd_pkg::PROD_W-1:0] prod,
      input wpd_pkg::cfg_type           c
   );
      logic [wpd_pkg::PROD_W-1:0]  biased;
      logic [wpd_pkg::ROUND_W-1:0] rounded;
      logic [wpd_pkg::PSUM_W-1:0]  padded;
      logic [wpd_pkg::ROW_W-1:0]   row;
      biased  = prod + wpd_pkg::PROD_W'({1'b1, {(wpd_pkg::SAMPLE_BITS-1){1'b0}}});
      rounded = biased[wpd_pkg::PROD_W-1:wpd_pkg::SAMPLE_BITS];
      padded  = wpd_pkg::PSUM_W'(rounded) + wpd_pkg::PSUM_W'(c.padding);
      if (c.height_small) begin
         row = '0;
      end else if (padded > wpd_pkg::PSUM_W'(c.row_limit)) begin
         row = c.row_limit[wpd_pkg::ROW_W-1:0];
      end else begin
         row = padded[wpd_pkg::ROW_W-1:0];
      end
      return row;
   endfunction

   logic                  accept;
   logic                  valid_ff, valid_in;
   wpd_pkg::rsp_word_type data_ff, data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in.first_value  = in_data.first_value;
      data_in.second_value = in_data.second_value;
      data_in.first_row    = to_row(in_data.first_prod, cfg);
      data_in.second_row   = to_row(in_data.second_prod, cfg);
      data_in.flat_block   = in_data.flat_block;
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- design/waveform_peak_decimator_top.sv -----
// top level of the min/max waveform peak decimator
//
//   channel  direction  handshake          word
//   req      in         req_valid/ready    sample, block_end
//   rsp      out        rsp_valid/ready    extremes in time order, rows, flat mark
//   csr      in         csr_write_en       channel_count, image_height, edge_padding
//
// one sample is taken every cycle unless a stalled result backs up to the tracker; each block end
// gives one result, registered in turn by the tracker, multiplier and clamp registers
// every stage has its own register, so a stalled result holds only the stages behind it
// synchronous reset clears the block state and the stage valids, and sets the configuration to its reset values
module waveform_peak_decimator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  wpd_pkg::req_word_type                req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output wpd_pkg::rsp_word_type                rsp_data,
   input  logic                                 csr_write_en,
   input  logic [wpd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [wpd_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   logic [wpd_pkg::CHAN_W-1:0]   chans_ff;
   logic [wpd_pkg::HEIGHT_W-1:0] height_ff;
   logic [wpd_pkg::PAD_W-1:0]    pad_ff;
   wpd_pkg::cfg_type             cfg;

   logic                     closed_valid, closed_ready;
   wpd_pkg::closed_word_type closed_data;
   logic                     scaled_valid, scaled_ready;
   wpd_pkg::scaled_word_type scaled_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chans_ff  <= wpd_pkg::CHAN_RESET;
         height_ff <= wpd_pkg::HEIGHT_RESET;
         pad_ff    <= wpd_pkg::PAD_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            wpd_pkg::CSR_CHANNEL_COUNT: chans_ff  <= csr_write_data[wpd_pkg::CHAN_W-1:0];
            wpd_pkg::CSR_IMAGE_HEIGHT:  height_ff <= csr_write_data[wpd_pkg::HEIGHT_W-1:0];
            wpd_pkg::CSR_EDGE_PADDING:  pad_ff    <= csr_write_data[wpd_pkg::PAD_W-1:0];
            default: ;
         endcase
      end
   end

   // cleaned configuration values
   always_comb begin
      if (chans_ff < wpd_pkg::CHAN_MIN) begin
         cfg.chans = wpd_pkg::CHAN_MIN;
      end else if (chans_ff > wpd_pkg::CHAN_MAX) begin
         cfg.chans = wpd_pkg::CHAN_MAX;
      end else begin
         cfg.chans = chans_ff;
      end
      if (height_ff > wpd_pkg::HEIGHT_MAX) begin
         cfg.height = wpd_pkg::HEIGHT_MAX;
      end else begin
         cfg.height = height_ff;
      end
      cfg.height_small = (height_ff < wpd_pkg::HEIGHT_MIN);
      cfg.row_limit    = cfg.height - wpd_pkg::HEIGHT_MIN;
      cfg.padding      = pad_ff;
   end

   // block tracking
   wpd_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (closed_valid),
      .out_ready (closed_ready),
      .out_data  (closed_data)
   );

   // height scaling
   wpd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (closed_valid),
      .in_ready  (closed_ready),
      .in_data   (closed_data),
      .out_valid (scaled_valid),
      .out_ready (scaled_ready),
      .out_data  (scaled_data)
   );

   // row mapping and result register
   wpd_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (scaled_valid),
      .in_ready  (scaled_ready),
      .in_data   (scaled_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

// ----- verif/waveform_peak_decimator_checker.sv -----
// checker for the waveform peak decimator: predicts each block's peak pair and compares
module waveform_peak_decimator_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  wpd_pkg::req_word_type             req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  wpd_pkg::rsp_word_type             rsp_data,
   input  logic                              csr_write_en,
   input  logic [wpd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wpd_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output int                                failure_count,
   output int                                peaks_pending,
   output int                                peaks_checked
);

   localparam longint HALF_SCALE   = longint'(1) << (wpd_pkg::SAMPLE_BITS - 1);
   localparam int     REPORT_LIMIT = 10;

   // mirrored configuration
   logic [wpd_pkg::CHAN_W-1:0]   set_chans  = wpd_pkg::CHAN_RESET;
   logic [wpd_pkg::HEIGHT_W-1:0] set_height = wpd_pkg::HEIGHT_RESET;
   logic [wpd_pkg::PAD_W-1:0]    set_pad    = wpd_pkg::PAD_RESET;

   // running block state
   logic signed [wpd_pkg::SAMPLE_BITS-1:0] low_mark     = '0;
   logic signed [wpd_pkg::SAMPLE_BITS-1:0] high_mark    = '0;
   logic                                   high_is_later = 1'b0;
   logic                                   block_open    = 1'b0;
   int                                     frame_pos     = 0;

   wpd_pkg::rsp_word_type peak_queue[$];
   int                    fail_tally    = 0;
   int                    checked_tally = 0;

   // image row of one extreme, rounded half up, padded and clamped
   function automatic logic [wpd_pkg::ROW_W-1:0] row_of(
      input logic signed [wpd_pkg::SAMPLE_BITS-1:0] value,
      input logic [wpd_pkg::HEIGHT_W-1:0]           height,
      input logic [wpd_pkg::PAD_W-1:0]              padding
   );
      longint rows;
      longint level;
      longint y;
      rows  = longint'(height);
      level = longint'(value);
      if (rows < longint'(wpd_pkg::HEIGHT_MIN)) return '0;
      if (rows > longint'(wpd_pkg::HEIGHT_MAX)) rows = longint'(wpd_pkg::HEIGHT_MAX);
      y = (rows * (HALF_SCALE - level) + HALF_SCALE) >>> wpd_pkg::SAMPLE_BITS;
      y = y + longint'(padding);
      if (y > rows - 2) y = rows - 2;
      return y[wpd_pkg::ROW_W-1:0];
   endfunction

   // fold one accepted sample word into the block, closing it on block end
   task automatic fold_sample(input wpd_pkg::req_word_type w);
      int                                     lanes;
      logic signed [wpd_pkg::SAMPLE_BITS-1:0] early;
      logic signed [wpd_pkg::SAMPLE_BITS-1:0] late;
      wpd_pkg::rsp_word_type                  peak;
      lanes = int'(set_chans);
      if (lanes < int'(wpd_pkg::CHAN_MIN)) lanes = int'(wpd_pkg::CHAN_MIN);
      if (lanes > int'(wpd_pkg::CHAN_MAX)) lanes = int'(wpd_pkg::CHAN_MAX);

      // only channel 0 counts; strict compares keep the first occurrence
      if (frame_pos == 0) begin
         if (!block_open) begin
            low_mark      = w.sample;
            high_mark     = w.sample;
            high_is_later = 1'b0;
            block_open    = 1'b1;
         end else begin
            if (w.sample > high_mark) begin
               high_mark     = w.sample;
               high_is_later = 1'b1;
            end
            if (w.sample < low_mark) begin
               low_mark      = w.sample;
               high_is_later = 1'b0;
            end
         end
      end
      if (frame_pos + 1 >= lanes) frame_pos = 0;
      else frame_pos = (frame_pos + 1) & 7;

      if (w.block_end) begin
         if (!block_open) begin
            low_mark      = '0;
            high_mark     = '0;
            high_is_later = 1'b0;
         end
         // maximum first unless it came strictly later
         if (high_is_later) begin
            early = low_mark;
            late  = high_mark;
         end else begin
            early = high_mark;
            late  = low_mark;
         end
         peak.first_value  = early;
         peak.second_value = late;
         peak.first_row    = row_of(early, set_height, set_pad);
         peak.second_row   = row_of(late, set_height, set_pad);
         peak.flat_block   = (early == late);
         peak_queue.insert(peak_queue.size(), peak);
         low_mark      = '0;
         high_mark     = '0;
         high_is_later = 1'b0;
         block_open    = 1'b0;
         frame_pos     = 0;
      end
   endtask

   // compare one accepted result word with the oldest prediction
   task automatic check_peak(input wpd_pkg::rsp_word_type got);
      wpd_pkg::rsp_word_type want;
      if (peak_queue.size() == 0) begin
         fail_tally++;
         if (fail_tally <= REPORT_LIMIT)
            $display("unexpected peak word: first %0d/%0d second %0d/%0d flat %0b",
                     got.first_value, got.first_row, got.second_value, got.second_row,
                     got.flat_block);
         return;
      end
      want = peak_queue.pop_front();
      checked_tally++;
      if (got.first_value !== want.first_value || got.second_value !== want.second_value ||
          got.first_row !== want.first_row || got.second_row !== want.second_row ||
          got.flat_block !== want.flat_block) begin
         fail_tally++;
         if (fail_tally <= REPORT_LIMIT) begin
            $display("peak mismatch: expected first %0d/%0d second %0d/%0d flat %0b",
                     want.first_value, want.first_row, want.second_value, want.second_row,
                     want.flat_block);
            $display("               got      first %0d/%0d second %0d/%0d flat %0b",
                     got.first_value, got.first_row, got.second_value, got.second_row,
                     got.flat_block);
         end
      end
   endtask

   // watch all three ports at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         set_chans     = wpd_pkg::CHAN_RESET;
         set_height    = wpd_pkg::HEIGHT_RESET;
         set_pad       = wpd_pkg::PAD_RESET;
         low_mark      = '0;
         high_mark     = '0;
         high_is_later = 1'b0;
         block_open    = 1'b0;
         frame_pos     = 0;
         peak_queue.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               wpd_pkg::CSR_CHANNEL_COUNT: set_chans  = csr_write_data[wpd_pkg::CHAN_W-1:0];
               wpd_pkg::CSR_IMAGE_HEIGHT:  set_height = csr_write_data[wpd_pkg::HEIGHT_W-1:0];
               wpd_pkg::CSR_EDGE_PADDING:  set_pad    = csr_write_data[wpd_pkg::PAD_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) fold_sample(req_data);
         if (rsp_valid && rsp_ready) check_peak(rsp_data);
      end
      failure_count <= fail_tally;
      peaks_pending <= peak_queue.size();
      peaks_checked <= checked_tally;
   end

endmodule

// ----- verif/tb_waveform_peak_decimator_top.sv -----
// testbench top for the waveform peak decimator: stimulus, back-pressure and verdict
module tb_waveform_peak_decimator_top;

   localparam int HALF_PERIOD   = 4;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_WORDS  = 500;
   localparam int PHASE_WORDS   = 60;
   localparam int TAIL_WORDS    = 80;
   localparam logic [wpd_pkg::CSR_INDEX_W-1:0] CSR_SPARE = wpd_pkg::CSR_INDEX_W'(3);

   logic                            clock          = 1'b0;
   logic                            reset          = 1'b1;
   logic                            req_valid      = 1'b0;
   logic                            req_ready;
   wpd_pkg::req_word_type           req_data       = '0;
   logic                            rsp_valid;
   logic                            rsp_ready      = 1'b0;
   wpd_pkg::rsp_word_type           rsp_data;
   logic                            csr_write_en   = 1'b0;
   logic [wpd_pkg::CSR_INDEX_W-1:0] csr_index      = '0;
   logic [wpd_pkg::CSR_DATA_W-1:0]  csr_write_data = '0;

   int failure_count;
   int peaks_pending;
   int peaks_checked;

   int   words_sent    = 0;
   int   settings_used = 1;
   int   send_gap_pct  = 0;
   int   stall_pct     = 0;
   bit   quiet_tail    = 1'b0;
   logic [wpd_pkg::CHAN_W-1:0]             live_chans  = wpd_pkg::CHAN_RESET;
   logic signed [wpd_pkg::SAMPLE_BITS-1:0] last_sample = '0;

   always #HALF_PERIOD clock = ~clock;

   waveform_peak_decimator_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   waveform_peak_decimator_checker peak_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .failure_count  (failure_count),
      .peaks_pending  (peaks_pending),
      .peaks_checked  (peaks_checked)
   );

   // result side stalls in bursts, none in the tail
   initial begin : rsp_stall
      int burst;
      forever begin
         @(negedge clock);
         if (!quiet_tail && stall_pct > 0 && $urandom_range(99) < stall_pct) begin
            burst = $urandom_range(1, 15);
            rsp_ready = 1'b0;
            repeat (burst) @(negedge clock);
         end
         rsp_ready = 1'b1;
      end
   end

   // drive one sample word, maybe after a gap, and hold it until taken
   task automatic send_word(input logic signed [wpd_pkg::SAMPLE_BITS-1:0] value,
                            input logic last);
      int gap;
      @(negedge clock);
      if (!quiet_tail && send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         gap = $urandom_range(1, 15);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data.sample    = value;
      req_data.block_end = last;
      req_valid          = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // sample mix: full scale, near zero, repeats for ties, and anything
   function automatic logic signed [wpd_pkg::SAMPLE_BITS-1:0] next_sample();
      logic signed [wpd_pkg::SAMPLE_BITS-1:0] v;
      case ($urandom_range(9))
         0:       v = 16'sh7FFF;
         1:       v = 16'sh8000;
         2:       v = wpd_pkg::SAMPLE_BITS'(int'($urandom_range(8)) - 4);
         3:       v = last_sample;
         default: v = wpd_pkg::SAMPLE_BITS'($urandom);
      endcase
      last_sample = v;
      return v;
   endfunction

   // a run of random samples, closing the block on the last one if asked
   task automatic send_run(input int count, input logic closes);
      for (int i = 0; i < count; i++)
         send_word(next_sample(), closes && (i == count - 1));
   endtask

   function automatic int effective_lanes(input logic [wpd_pkg::CHAN_W-1:0] chans);
      if (chans < wpd_pkg::CHAN_MIN) return int'(wpd_pkg::CHAN_MIN);
      if (chans > wpd_pkg::CHAN_MAX) return int'(wpd_pkg::CHAN_MAX);
      return int'(chans);
   endfunction

   function automatic int idle_rate();
      case ($urandom_range(2))
         0:       return 0;
         1:       return 10;
         default: return 40;
      endcase
   endfunction

   // stop sending, wait for every predicted result, then let the pipe settle
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (peaks_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [wpd_pkg::CSR_INDEX_W-1:0] index,
                            input logic [wpd_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en   = 1'b1;
      csr_index      = index;
      csr_write_data = data;
      @(negedge clock);
      csr_write_en   = 1'b0;
   endtask

   // new setting once idle; unused upper bits carry junk
   task automatic apply_setting(input logic [wpd_pkg::CHAN_W-1:0] chans,
                                input logic [wpd_pkg::HEIGHT_W-1:0] height,
                                input logic [wpd_pkg::PAD_W-1:0] padding);
      logic [wpd_pkg::CSR_DATA_W-1:0] data;
      drain();
      data = wpd_pkg::CSR_DATA_W'($urandom);
      data[wpd_pkg::CHAN_W-1:0] = chans;
      write_reg(wpd_pkg::CSR_CHANNEL_COUNT, data);
      write_reg(wpd_pkg::CSR_IMAGE_HEIGHT, wpd_pkg::CSR_DATA_W'(height));
      data = wpd_pkg::CSR_DATA_W'($urandom);
      data[wpd_pkg::PAD_W-1:0] = padding;
      write_reg(wpd_pkg::CSR_EDGE_PADDING, data);
      live_chans = chans;
      settings_used++;
   endtask

   initial begin : stimulus
      int phase;
      int target;
      int phase_end;
      int n;
      logic [wpd_pkg::CHAN_W-1:0]   chans;
      logic [wpd_pkg::HEIGHT_W-1:0] height;

      repeat (4) @(negedge clock);
      reset = 1'b0;

      // the spare index must leave everything alone
      write_reg(CSR_SPARE, wpd_pkg::CSR_DATA_W'($urandom));
      send_gap_pct = 20;
      stall_pct    = 20;

      // one-frame blocks at full scale and zero
      send_word(16'sh7FFF, 1'b1);
      send_word(16'sh8000, 1'b1);
      send_word(16'sh0000, 1'b1);
      // flat block with a tie
      send_word(16'sd100, 1'b0);
      send_word(16'sd100, 1'b1);
      // maximum later, then minimum later with repeated extremes
      send_word(-16'sd5, 1'b0);
      send_word(16'sd7, 1'b0);
      send_word(16'sd3, 1'b1);
      send_word(16'sd7, 1'b0);
      send_word(16'sd7, 1'b0);
      send_word(-16'sd5, 1'b0);
      send_word(-16'sd5, 1'b1);
      send_word(16'sh8000, 1'b0);
      send_word(16'sh7FFF, 1'b1);

      // two channels: the second channel must be ignored
      apply_setting(wpd_pkg::CHAN_W'(2), wpd_pkg::HEIGHT_RESET, wpd_pkg::PAD_RESET);
      send_word(16'sd10, 1'b0);
      send_word(16'sd30000, 1'b0);
      send_word(-16'sd10, 1'b0);
      send_word(-16'sd30000, 1'b1);
      // block end in the middle of a frame
      send_word(16'sd5, 1'b1);
      send_word(16'sd6, 1'b0);
      send_word(16'sd7, 1'b1);

      // random phases, each under its own setting
      target = words_sent + RANDOM_WORDS;
      phase  = 0;
      while (words_sent < target) begin
         if (target - words_sent <= TAIL_WORDS) quiet_tail = 1'b1;
         case (phase)
            0: apply_setting(wpd_pkg::CHAN_W'(8), wpd_pkg::HEIGHT_W'(4096),
                             wpd_pkg::PAD_W'(255));
            1: apply_setting(wpd_pkg::CHAN_W'(1), wpd_pkg::HEIGHT_W'(2),
                             wpd_pkg::PAD_W'(0));
            2: apply_setting(wpd_pkg::CHAN_W'(0), wpd_pkg::HEIGHT_W'(8191),
                             wpd_pkg::PAD_W'(0));
            3: apply_setting(wpd_pkg::CHAN_W'(15), wpd_pkg::HEIGHT_W'(1),
                             wpd_pkg::PAD_W'(7));
            4: apply_setting(wpd_pkg::CHAN_W'(3), wpd_pkg::HEIGHT_W'(0),
                             wpd_pkg::PAD_W'(128));
            5: apply_setting(wpd_pkg::CHAN_W'(5), wpd_pkg::HEIGHT_W'(4097),
                             wpd_pkg::PAD_W'(255));
            default: begin
               if ($urandom_range(4) == 0) chans = wpd_pkg::CHAN_W'($urandom_range(15));
               else chans = wpd_pkg::CHAN_W'($urandom_range(1, 8));
               if ($urandom_range(1) == 0)
                  height = wpd_pkg::HEIGHT_W'($urandom_range(2, 40));
               else
                  height = wpd_pkg::HEIGHT_W'($urandom_range(2, 4096));
               apply_setting(chans, height, wpd_pkg::PAD_W'($urandom_range(255)));
            end
         endcase
         send_gap_pct = idle_rate();
         stall_pct    = idle_rate();

         // whole frames mostly, sometimes a block cut short mid-frame
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end && words_sent < target) begin
            n = $urandom_range(1, 4) * effective_lanes(live_chans);
            if ($urandom_range(4) == 0) n = $urandom_range(1, n);
            send_run(n, 1'b1);
         end

         // leave a frame open across the next setting change now and then
         if (!quiet_tail && $urandom_range(2) == 0) send_run($urandom_range(1, 3), 1'b0);
         phase++;
      end

      drain();
      $display("%0d sample words sent under %0d settings, %0d peak pairs checked",
               words_sent, settings_used, peaks_checked);
      if (failure_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // hard stop if the handshakes hang
   initial begin : watchdog
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- waveform_peak_decimator_top.f -----
design/wpd_pkg.sv
design/wpd_tracker.sv
design/wpd_scale.sv
design/wpd_clamp.sv
design/waveform_peak_decimator_top.sv
verif/waveform_peak_decimator_checker.sv
verif/tb_waveform_peak_decimator_top.sv
